### design/ngcs_pkg.sv
// Shared types and constants for the sorted grid neighborhood block.
package ngcs_pkg;

   localparam int MAX_RADIUS_DEF = 3;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SIZE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_RADIUS = 1'b1;

   localparam logic [15:0] CELL_SIZE_RESET   = 16'd256;
   localparam logic [1:0]  VIEW_RADIUS_RESET = 2'd2;

   localparam int CENTRE_W = 16;
   localparam int CAMERA_W = 32;
   localparam int CELL_W   = 17;
   localparam int PROD_W   = 34;
   localparam int ABS_W    = 33;
   localparam int SQ_W     = 66;
   localparam int KEY_W    = 67;

   typedef struct packed {
      logic load;
      logic sq_run;
      logic scan_run;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic sq_last;
      logic scan_last;
      logic run_last;
      logic out_free;
   } status_type;

endpackage

### design/ngcs_ctrl.sv
// Sequencer: square phase, selection scans and result emission.
module ngcs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ngcs_pkg::status_type st,
   output ngcs_pkg::cmd_type    cmd
);
   import ngcs_pkg::*;

   typedef enum logic [1:0] {IDLE, SQUARE, SCAN, EMIT} state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = SQUARE;
            end
         end
         SQUARE: begin
            cmd.sq_run = 1'b1;
            if (st.sq_last) state_in = SCAN;
         end
         SCAN: begin
            cmd.scan_run = 1'b1;
            if (st.scan_last) state_in = EMIT;
         end
         EMIT: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = st.run_last ? IDLE : SCAN;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   assign req_stall = (state_ff != IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/ngcs_dp.sv
// Datapath: config, per-axis squared distances, selection scan, output register.
module ngcs_dp #(
   parameter int MAX_RADIUS = ngcs_pkg::MAX_RADIUS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [ngcs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ngcs_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic signed [ngcs_pkg::CENTRE_W-1:0]   req_centre_x,
   input  logic signed [ngcs_pkg::CENTRE_W-1:0]   req_centre_z,
   input  logic signed [ngcs_pkg::CAMERA_W-1:0]   req_camera_x,
   input  logic signed [ngcs_pkg::CAMERA_W-1:0]   req_camera_z,
   input  ngcs_pkg::cmd_type                      cmd,
   output ngcs_pkg::status_type                   st,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [ngcs_pkg::CELL_W-1:0]     rsp_cell_x,
   output logic signed [ngcs_pkg::CELL_W-1:0]     rsp_cell_z,
   output logic                                   rsp_is_last
);
   import ngcs_pkg::*;

   localparam int SIDE  = 2 * MAX_RADIUS + 1;
   localparam int CELLS = SIDE * SIDE;
   localparam int IW    = (SIDE > 1) ? $clog2(SIDE) : 1;
   localparam int CIW   = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam logic [1:0] MAX_R = 2'(MAX_RADIUS);

   typedef enum logic [2:0] {
      PH_CELL, PH_ABS, PH_LO_LO, PH_CROSS, PH_HI_HI
   } phase_type;

   logic [15:0]               cs_ff;
   logic [1:0]                vr_ff;
   logic [1:0]                r_ff;
   logic [CENTRE_W-1:0]       cx_ff, cz_ff;
   logic [CAMERA_W-1:0]       camx_ff, camz_ff;

   phase_type                 ph_ff;
   logic [IW-1:0]             k_ff;
   logic                      axis_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [ABS_W-1:0]          abs_ff;
   logic [SQ_W-1:0]           acc_ff;
   logic [SQ_W-1:0]           xsq_ff [SIDE];
   logic [SQ_W-1:0]           zsq_ff [SIDE];

   logic [IW-1:0]             sx_ff, sz_ff;
   logic [CIW-1:0]            scan_i_ff;
   logic                      found_ff;
   logic [KEY_W-1:0]          best_key_ff;
   logic [CIW-1:0]            best_i_ff;
   logic [IW-1:0]             best_sx_ff, best_sz_ff;
   logic [CELLS-1:0]          done_ff;
   logic [CIW-1:0]            emit_cnt_ff;

   logic                      rsp_valid_ff;
   logic [CELL_W-1:0]         rsp_cell_x_ff, rsp_cell_z_ff;
   logic                      rsp_is_last_ff;

   logic [IW-1:0]             last_k;
   logic [2:0]                side_eff;
   logic [5:0]                side_sq;
   logic [CIW-1:0]            count_m1;
   logic [CENTRE_W-1:0]       base;
   logic [CAMERA_W-1:0]       cam;
   logic [CELL_W-1:0]         off, cell_idx;
   logic signed [PROD_W-1:0]  prod_in;
   logic [PROD_W-1:0]         diff;
   logic [ABS_W-1:0]          abs_in;
   logic [16:0]               opa, opb;
   logic [PROD_W-1:0]         mp;
   logic [KEY_W-1:0]          key;
   logic                      better;
   logic [1:0]                r_in;

   assign last_k   = IW'({r_ff, 1'b0});
   assign side_eff = {r_ff, 1'b1};
   assign side_sq  = {3'b000, side_eff} * {3'b000, side_eff};
   assign count_m1 = CIW'(side_sq - 6'd1);
   assign r_in     = (vr_ff > MAX_R) ? MAX_R : vr_ff;

   // cell index of the current square: centre + (k - r)
   assign base     = axis_ff ? cz_ff : cx_ff;
   assign cam      = axis_ff ? camz_ff : camx_ff;
   assign off      = CELL_W'(k_ff) - CELL_W'(r_ff);
   assign cell_idx = {base[CENTRE_W-1], base} + off;
   assign prod_in  = $signed(cell_idx) * $signed({1'b0, cs_ff});
   assign diff     = prod_ff - {{(PROD_W-CAMERA_W){cam[CAMERA_W-1]}}, cam};
   assign abs_in   = diff[PROD_W-1] ? ABS_W'(-diff) : diff[ABS_W-1:0];

   // |d| = ah*2^17 + al; d^2 built from three 17x17 partial products
   assign opa = (ph_ff == PH_LO_LO) ? abs_ff[16:0] : {1'b0, abs_ff[32:17]};
   assign opb = (ph_ff == PH_HI_HI) ? {1'b0, abs_ff[32:17]} : abs_ff[16:0];
   assign mp  = {17'd0, opa} * {17'd0, opb};

   assign key    = {1'b0, xsq_ff[sx_ff]} + {1'b0, zsq_ff[sz_ff]};
   // scan runs z-major, so strict less keeps ties on smaller z, then x
   assign better = !done_ff[scan_i_ff] && (!found_ff || key < best_key_ff);

   assign st.sq_last   = (ph_ff == PH_HI_HI) && (k_ff == last_k) && axis_ff;
   assign st.scan_last = (sx_ff == last_k) && (sz_ff == last_k);
   assign st.run_last  = (emit_cnt_ff == count_m1);
   assign st.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_cell_x  = rsp_cell_x_ff;
   assign rsp_cell_z  = rsp_cell_z_ff;
   assign rsp_is_last = rsp_is_last_ff;

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff   <= req_centre_x;
         cz_ff   <= req_centre_z;
         camx_ff <= req_camera_x;
         camz_ff <= req_camera_z;
         r_ff    <= r_in;
      end
      if (cmd.sq_run) begin
         unique case (ph_ff)
            PH_CELL:  prod_ff <= prod_in;
            PH_ABS:   abs_ff  <= abs_in;
            PH_LO_LO: acc_ff  <= SQ_W'(mp);
            PH_CROSS: acc_ff  <= acc_ff + (SQ_W'(mp) << 18);
            PH_HI_HI: begin
               if (axis_ff) zsq_ff[k_ff] <= acc_ff + (SQ_W'(mp) << 34);
               else         xsq_ff[k_ff] <= acc_ff + (SQ_W'(mp) << 34);
            end
            default: acc_ff <= acc_ff;
         endcase
      end
      if (cmd.scan_run && better) begin
         best_key_ff <= key;
         best_i_ff   <= scan_i_ff;
         best_sx_ff  <= sx_ff;
         best_sz_ff  <= sz_ff;
      end
      if (cmd.emit) begin
         rsp_cell_x_ff  <= {cx_ff[CENTRE_W-1], cx_ff} + CELL_W'(best_sx_ff) - CELL_W'(r_ff);
         rsp_cell_z_ff  <= {cz_ff[CENTRE_W-1], cz_ff} + CELL_W'(best_sz_ff) - CELL_W'(r_ff);
         rsp_is_last_ff <= st.run_last;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff        <= CELL_SIZE_RESET;
         vr_ff        <= VIEW_RADIUS_RESET;
         ph_ff        <= PH_CELL;
         k_ff         <= '0;
         axis_ff      <= 1'b0;
         sx_ff        <= '0;
         sz_ff        <= '0;
         scan_i_ff    <= '0;
         found_ff     <= 1'b0;
         done_ff      <= '0;
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            priority if (csr_index == CSR_CELL_SIZE)   cs_ff <= csr_wdata;
            else if (csr_index == CSR_VIEW_RADIUS)     vr_ff <= csr_wdata[1:0];
         end
         if (!cmd.emit && rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (cmd.load) begin
            ph_ff       <= PH_CELL;
            k_ff        <= '0;
            axis_ff     <= 1'b0;
            sx_ff       <= '0;
            sz_ff       <= '0;
            scan_i_ff   <= '0;
            found_ff    <= 1'b0;
            done_ff     <= '0;
            emit_cnt_ff <= '0;
         end
         if (cmd.sq_run) begin
            unique case (ph_ff)
               PH_CELL:  ph_ff <= PH_ABS;
               PH_ABS:   ph_ff <= PH_LO_LO;
               PH_LO_LO: ph_ff <= PH_CROSS;
               PH_CROSS: ph_ff <= PH_HI_HI;
               PH_HI_HI: begin
                  ph_ff <= PH_CELL;
                  if (k_ff == last_k) begin
                     k_ff    <= '0;
                     axis_ff <= !axis_ff;
                  end else begin
                     k_ff <= k_ff + 1'b1;
                  end
               end
               default: ph_ff <= PH_CELL;
            endcase
         end
         if (cmd.scan_run) begin
            if (better) found_ff <= 1'b1;
            scan_i_ff <= scan_i_ff + 1'b1;
            if (sx_ff == last_k) begin
               sx_ff <= '0;
               sz_ff <= sz_ff + 1'b1;
            end else begin
               sx_ff <= sx_ff + 1'b1;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff       <= 1'b1;
            done_ff[best_i_ff] <= 1'b1;
            emit_cnt_ff        <= emit_cnt_ff + 1'b1;
            found_ff           <= 1'b0;
            sx_ff              <= '0;
            sz_ff              <= '0;
            scan_i_ff          <= '0;
         end
      end
   end

endmodule

### design/nearest_grid_cells_sorted.sv
// Top level: grid cells around a centre, emitted nearest to the camera first.
//
//   channel  dir  handshake            beat
//   req      in   req_valid/req_stall  centre_x, centre_z, camera_x, camera_z
//   rsp      out  rsp_valid/rsp_stall  cell_x, cell_z, is_last
//   csr      in   csr_write            csr_index, csr_wdata
//
// One request at a time. With side s = 2r+1 and n = s*s cells, a request first
// builds the per-axis squares (one 17x17 multiplier shared by the partial
// products, five steps per square), then runs n selection scans, each followed
// by an emit step. Synchronous reset clears control and loads the register
// defaults. A stalled result holds the block in its emit step.
module nearest_grid_cells_sorted #(
   parameter int MAX_RADIUS = ngcs_pkg::MAX_RADIUS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [ngcs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ngcs_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [ngcs_pkg::CENTRE_W-1:0]   req_centre_x,
   input  logic signed [ngcs_pkg::CENTRE_W-1:0]   req_centre_z,
   input  logic signed [ngcs_pkg::CAMERA_W-1:0]   req_camera_x,
   input  logic signed [ngcs_pkg::CAMERA_W-1:0]   req_camera_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [ngcs_pkg::CELL_W-1:0]     rsp_cell_x,
   output logic signed [ngcs_pkg::CELL_W-1:0]     rsp_cell_z,
   output logic                                   rsp_is_last
);
   import ngcs_pkg::*;

   cmd_type    cmd;
   status_type st;

   ngcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   ngcs_dp #(.MAX_RADIUS(MAX_RADIUS)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_centre_x (req_centre_x),
      .req_centre_z (req_centre_z),
      .req_camera_x (req_camera_x),
      .req_camera_z (req_camera_z),
      .cmd          (cmd),
      .st           (st),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_cell_x   (rsp_cell_x),
      .rsp_cell_z   (rsp_cell_z),
      .rsp_is_last  (rsp_is_last)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted but block not busy");

   a_emit_shows_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("emit did not raise rsp_valid");

   a_emit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid && rsp_stall))
      else $error("emit overwrote a stalled beat");

   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.sq_run, cmd.scan_run, cmd.emit}))
      else $error("more than one datapath command");

endmodule
